// ===== rtl/hmp_pkg.sv =====
// Shared types, codes and defaults for the indexed min-heap.
`default_nettype none
package hmp_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int ID_COUNT_DEF  = 256;
   localparam int KEY_WIDTH_DEF = 32;

   // request codes
   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_ERASE  = 2'd2;
   localparam logic [1:0] REQ_LOOKUP = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_PRESENT = 3'd4;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ERR,
      CMD_PUSH_START,
      CMD_POP_START,
      CMD_POS_RD,
      CMD_HEAP_RD_POS,
      CMD_CAPTURE,
      CMD_RD_PARENT,
      CMD_MOVE_PARENT,
      CMD_PLACE,
      CMD_REMOVE,
      CMD_LAST,
      CMD_RD_L,
      CMD_HOLD_L,
      CMD_MOVE_CHILD,
      CMD_PUBLISH
   } cmd_type;

   typedef struct packed {
      logic [2:0] err;
      logic [1:0] op;
      logic       idx_zero;
      logic       size_zero;
      logic       l_out;
      logic       up_less;
      logic       dn_go;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/hmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== rtl/hmp_ctrl.sv =====
// Sequencer for the heap: steps one request through reads, sifts and the result.
`default_nettype none
module hmp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output hmp_pkg::cmd_type           cmd,
   input  wire hmp_pkg::dp_status_type dps
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_POS_WAIT,
      S_ENT_WAIT,
      S_UP_RD,
      S_UP_CMP,
      S_LAST_WAIT,
      S_DN_L,
      S_DN_R,
      S_DN_CMP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = hmp_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = hmp_pkg::CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (dps.err != hmp_pkg::ST_OK) begin
               cmd      = hmp_pkg::CMD_ERR;
               state_in = S_DONE;
            end else if (dps.op == hmp_pkg::REQ_PUSH) begin
               cmd      = hmp_pkg::CMD_PUSH_START;
               state_in = S_UP_RD;
            end else if (dps.op == hmp_pkg::REQ_POP) begin
               cmd      = hmp_pkg::CMD_POP_START;
               state_in = S_ENT_WAIT;
            end else begin
               cmd      = hmp_pkg::CMD_POS_RD;
               state_in = S_POS_WAIT;
            end
         end
         S_POS_WAIT: begin
            cmd      = hmp_pkg::CMD_HEAP_RD_POS;
            state_in = S_ENT_WAIT;
         end
         S_ENT_WAIT: begin
            cmd      = hmp_pkg::CMD_CAPTURE;
            state_in = (dps.op == hmp_pkg::REQ_LOOKUP) ? S_DONE : S_UP_RD;
         end
         S_UP_RD: begin
            if (dps.idx_zero) begin
               if (dps.op == hmp_pkg::REQ_PUSH) begin
                  cmd      = hmp_pkg::CMD_PLACE;
                  state_in = S_DONE;
               end else begin
                  cmd      = hmp_pkg::CMD_REMOVE;
                  state_in = S_LAST_WAIT;
               end
            end else begin
               cmd      = hmp_pkg::CMD_RD_PARENT;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // erase climbs to the root unconditionally
            if (dps.op != hmp_pkg::REQ_PUSH || dps.up_less) begin
               cmd      = hmp_pkg::CMD_MOVE_PARENT;
               state_in = S_UP_RD;
            end else begin
               cmd      = hmp_pkg::CMD_PLACE;
               state_in = S_DONE;
            end
         end
         S_LAST_WAIT: begin
            cmd      = hmp_pkg::CMD_LAST;
            state_in = dps.size_zero ? S_DONE : S_DN_L;
         end
         S_DN_L: begin
            if (dps.l_out) begin
               cmd      = hmp_pkg::CMD_PLACE;
               state_in = S_DONE;
            end else begin
               cmd      = hmp_pkg::CMD_RD_L;
               state_in = S_DN_R;
            end
         end
         S_DN_R: begin
            cmd      = hmp_pkg::CMD_HOLD_L;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (dps.dn_go) begin
               cmd      = hmp_pkg::CMD_MOVE_CHILD;
               state_in = S_DN_L;
            end else begin
               cmd      = hmp_pkg::CMD_PLACE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // publish once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = hmp_pkg::CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/hmp_dp.sv =====
// Heap datapath: entry and position memories, presence bits, sift registers.
`default_nettype none
module hmp_dp #(
   parameter int CAPACITY  = hmp_pkg::CAPACITY_DEF,
   parameter int ID_COUNT  = hmp_pkg::ID_COUNT_DEF,
   parameter int KEY_WIDTH = hmp_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hmp_pkg::cmd_type       cmd,
   output hmp_pkg::dp_status_type      dps,
   input  wire logic [1:0]             req_type,
   input  wire logic [7:0]             req_item_id,
   input  wire logic [31:0]            req_item_key,
   output logic      [2:0]             rsp_status,
   output logic      [31:0]            rsp_out_key,
   output logic      [7:0]             rsp_out_id,
   output logic      [8:0]             rsp_entry_count
);

   localparam int PW = $clog2(CAPACITY);
   localparam int SW = PW + 1;
   localparam int IW = $clog2(ID_COUNT);
   localparam int EW = KEY_WIDTH + IW;

   logic [1:0]                  op_ff;
   logic [7:0]                  id_ff;
   logic signed [KEY_WIDTH-1:0] key_ff;
   logic [SW-1:0]               size_ff;
   logic [PW-1:0]               idx_ff;
   logic [EW-1:0]               mv_ff;
   logic [EW-1:0]               ch_ff;
   logic [PW-1:0]               ch_idx_ff;
   logic [EW-1:0]               res_ff;
   logic [2:0]                  sts_ff;
   logic [ID_COUNT-1:0]         present_ff;

   logic          heap_we, pos_we;
   logic [PW-1:0] heap_waddr, heap_raddr, pos_wdata, pos_rdata;
   logic [EW-1:0] heap_wdata, heap_rdata;
   logic [IW-1:0] pos_waddr, pos_raddr;

   hmp_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap_ram (
      .clock (clock),
      .we    (heap_we),
      .waddr (heap_waddr),
      .wdata (heap_wdata),
      .raddr (heap_raddr),
      .rdata (heap_rdata)
   );

   hmp_ram #(.WIDTH(PW), .DEPTH(ID_COUNT)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (pos_waddr),
      .wdata (pos_wdata),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   logic [IW-1:0]               id_ix;
   logic                        id_oob, id_pres;
   logic [2:0]                  err;
   logic [PW-1:0]               parent;
   logic [SW-1:0]               lchild, last_pos;
   logic [SW:0]                 rchild;
   logic                        r_in;
   logic signed [KEY_WIDTH-1:0] mv_key, rd_key, ch_key, sel_key;
   logic [EW-1:0]               sel;
   logic [PW-1:0]               sel_idx;

   always_comb begin
      id_ix   = IW'(id_ff);
      id_oob  = 32'(id_ff) >= 32'(ID_COUNT);
      id_pres = id_oob ? 1'b0 : present_ff[id_ix];
      case (op_ff)
         hmp_pkg::REQ_PUSH: begin
            if (id_oob) begin
               err = hmp_pkg::ST_ABSENT;
            end else if (id_pres) begin
               err = hmp_pkg::ST_PRESENT;
            end else if (size_ff == SW'(CAPACITY)) begin
               err = hmp_pkg::ST_FULL;
            end else begin
               err = hmp_pkg::ST_OK;
            end
         end
         hmp_pkg::REQ_POP: begin
            err = (size_ff == '0) ? hmp_pkg::ST_EMPTY : hmp_pkg::ST_OK;
         end
         default: begin
            err = id_pres ? hmp_pkg::ST_OK : hmp_pkg::ST_ABSENT;
         end
      endcase

      parent   = PW'((idx_ff - PW'(1)) >> 1);
      lchild   = {idx_ff, 1'b1};
      rchild   = {1'b0, lchild} + (SW+1)'(1);
      r_in     = rchild < {1'b0, size_ff};
      last_pos = size_ff - SW'(1);

      mv_key  = mv_ff[EW-1:IW];
      rd_key  = heap_rdata[EW-1:IW];
      ch_key  = ch_ff[EW-1:IW];
      // right child wins only when strictly smaller
      if (r_in && (rd_key < ch_key)) begin
         sel     = heap_rdata;
         sel_idx = PW'(rchild);
      end else begin
         sel     = ch_ff;
         sel_idx = ch_idx_ff;
      end
      sel_key = sel[EW-1:IW];

      dps.err       = err;
      dps.op        = op_ff;
      dps.idx_zero  = (idx_ff == '0);
      dps.size_zero = (size_ff == '0);
      dps.l_out     = (lchild >= size_ff);
      dps.up_less   = (mv_key < rd_key);
      dps.dn_go     = (sel_key < mv_key);
   end

   // memory ports
   always_comb begin
      heap_we    = 1'b0;
      heap_waddr = idx_ff;
      heap_wdata = mv_ff;
      heap_raddr = '0;
      pos_we     = 1'b0;
      pos_waddr  = mv_ff[IW-1:0];
      pos_wdata  = idx_ff;
      pos_raddr  = id_ix;
      case (cmd)
         hmp_pkg::CMD_HEAP_RD_POS: heap_raddr = pos_rdata;
         hmp_pkg::CMD_RD_PARENT:   heap_raddr = parent;
         hmp_pkg::CMD_REMOVE:      heap_raddr = PW'(last_pos);
         hmp_pkg::CMD_RD_L:        heap_raddr = PW'(lchild);
         hmp_pkg::CMD_HOLD_L:      heap_raddr = PW'(rchild);
         hmp_pkg::CMD_MOVE_PARENT: begin
            heap_we    = 1'b1;
            heap_wdata = heap_rdata;
            pos_we     = 1'b1;
            pos_waddr  = heap_rdata[IW-1:0];
         end
         hmp_pkg::CMD_PLACE: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
         end
         hmp_pkg::CMD_MOVE_CHILD: begin
            heap_we    = 1'b1;
            heap_wdata = sel;
            pos_we     = 1'b1;
            pos_waddr  = sel[IW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= '0;
         present_ff <= '0;
      end else begin
         case (cmd)
            hmp_pkg::CMD_PUSH_START: begin
               present_ff[id_ix] <= 1'b1;
               size_ff           <= size_ff + SW'(1);
            end
            hmp_pkg::CMD_REMOVE: begin
               present_ff[res_ff[IW-1:0]] <= 1'b0;
               size_ff                    <= last_pos;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         hmp_pkg::CMD_LOAD: begin
            op_ff  <= req_type;
            id_ff  <= req_item_id;
            key_ff <= KEY_WIDTH'($signed(req_item_key));
         end
         hmp_pkg::CMD_ERR: begin
            sts_ff <= err;
            res_ff <= '0;
         end
         hmp_pkg::CMD_PUSH_START: begin
            idx_ff <= PW'(size_ff);
            mv_ff  <= {key_ff, id_ix};
            sts_ff <= hmp_pkg::ST_OK;
            res_ff <= '0;
         end
         hmp_pkg::CMD_POP_START:   idx_ff <= '0;
         hmp_pkg::CMD_HEAP_RD_POS: idx_ff <= pos_rdata;
         hmp_pkg::CMD_CAPTURE: begin
            res_ff <= heap_rdata;
            mv_ff  <= heap_rdata;
            sts_ff <= hmp_pkg::ST_OK;
         end
         hmp_pkg::CMD_MOVE_PARENT: idx_ff <= parent;
         hmp_pkg::CMD_LAST: begin
            mv_ff  <= heap_rdata;
            idx_ff <= '0;
         end
         hmp_pkg::CMD_HOLD_L: begin
            ch_ff     <= heap_rdata;
            ch_idx_ff <= PW'(lchild);
         end
         hmp_pkg::CMD_MOVE_CHILD:  idx_ff <= sel_idx;
         hmp_pkg::CMD_PUBLISH: begin
            rsp_status      <= sts_ff;
            rsp_out_key     <= 32'($signed(res_ff[EW-1:IW]));
            rsp_out_id      <= 8'(res_ff[IW-1:0]);
            rsp_entry_count <= 9'(size_ff);
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/indexed_min_heap.sv =====
// Top level of the indexed min-heap: sequencer plus datapath.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_ready   req_type, req_item_id, req_item_key
//   rsp_     out        rsp_valid / rsp_ready   rsp_status, rsp_out_key, rsp_out_id,
//                                               rsp_entry_count
//
// One request at a time; req_ready is high only while the sequencer is idle.
// A push climbs level by level and stops below a parent that is not larger.
// A pop takes the root, moves the last entry there and sifts it down until
// no child is smaller or it has no child. Erase first climbs its entry to the
// root, then acts as a pop. Lookup reads the position memory, then the entry.
// Each step of a walk uses the single registered read port of the entry memory.
// A finished result sits in the output register while the next request is
// taken. Synchronous reset clears the presence bits and count at once.
`default_nettype none
module indexed_min_heap #(
   parameter int CAPACITY  = hmp_pkg::CAPACITY_DEF,
   parameter int ID_COUNT  = hmp_pkg::ID_COUNT_DEF,
   parameter int KEY_WIDTH = hmp_pkg::KEY_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_item_id,
   input  wire logic [31:0] req_item_key,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_out_key,
   output logic [7:0]       rsp_out_id,
   output logic [8:0]       rsp_entry_count
);

   hmp_pkg::cmd_type       cmd;
   hmp_pkg::dp_status_type dps;

   hmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .dps       (dps)
   );

   hmp_dp #(
      .CAPACITY  (CAPACITY),
      .ID_COUNT  (ID_COUNT),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dps             (dps),
      .req_type        (req_type),
      .req_item_id     (req_item_id),
      .req_item_key    (req_item_key),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_id      (rsp_out_id),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
`default_nettype wire

// ===== rtl/hmp_checker.sv =====
// Port-level checks for the indexed min-heap, bound to the top level.
`default_nettype none
module hmp_checker #(
   parameter int CAPACITY = hmp_pkg::CAPACITY_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_out_key,
   input wire logic [7:0]  rsp_out_id,
   input wire logic [8:0]  rsp_entry_count
);

   // one request in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_key) && $stable(rsp_out_id))
      else $error("stalled result changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != hmp_pkg::ST_OK |-> rsp_out_key == '0 && rsp_out_id == '0)
      else $error("error result carries data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= hmp_pkg::ST_PRESENT)
      else $error("bad status code");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entry_count) <= 32'(CAPACITY))
      else $error("entry count above capacity");

endmodule

bind indexed_min_heap hmp_checker #(.CAPACITY(CAPACITY)) u_hmp_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the indexed min-heap: random and directed requests.
`timescale 1ns / 100ps
`default_nettype none

class heap_scoreboard;
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] key;
      logic [7:0]  id;
      logic [8:0]  count;
   } rsp_type;

   logic signed [31:0] hkeys [256];
   logic [7:0]  hids [256];
   int          pos_of [256];
   bit          present [256];
   int          size;
   rsp_type     pending [$];
   int          errors;

   function new();
      size = 0;
      errors = 0;
      foreach (present[i]) present[i] = 0;
   endfunction

   function void swap_slots(int a, int b);
      logic signed [31:0] k;
      logic [7:0] d;
      k = hkeys[a]; d = hids[a];
      hkeys[a] = hkeys[b]; hids[a] = hids[b];
      hkeys[b] = k; hids[b] = d;
      pos_of[hids[a]] = a;
      pos_of[hids[b]] = b;
   endfunction

   function void sift_up(int i);
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!(hkeys[i] < hkeys[p])) break;
         swap_slots(i, p);
         i = p;
      end
   endfunction

   function void sift_down(int i);
      int l, r, c;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         if (l >= size) break;
         c = (r < size && hkeys[r] < hkeys[l]) ? r : l;
         if (!(hkeys[c] < hkeys[i])) break;
         swap_slots(c, i);
         i = c;
      end
   endfunction

   function void take_root(output logic [31:0] k, output logic [7:0] d);
      k = hkeys[0];
      d = hids[0];
      present[hids[0]] = 0;
      if (size > 1) begin
         hkeys[0] = hkeys[size - 1];
         hids[0] = hids[size - 1];
         pos_of[hids[0]] = 0;
      end
      size--;
      if (size > 0) sift_down(0);
   endfunction

   // predict the result of an accepted request
   function void note_request(logic [1:0] op, logic [7:0] id, logic [31:0] key);
      rsp_type r;
      int p;
      r = '0;
      r.status = hmp_pkg::ST_OK;
      case (op)
         hmp_pkg::REQ_PUSH: begin
            if (present[id]) r.status = hmp_pkg::ST_PRESENT;
            else if (size >= 256) r.status = hmp_pkg::ST_FULL;
            else begin
               hkeys[size] = key; hids[size] = id;
               pos_of[id] = size; present[id] = 1;
               size++;
               sift_up(size - 1);
            end
         end
         hmp_pkg::REQ_POP: begin
            if (size == 0) r.status = hmp_pkg::ST_EMPTY;
            else take_root(r.key, r.id);
         end
         default: begin
            if (!present[id]) r.status = hmp_pkg::ST_ABSENT;
            else if (op == hmp_pkg::REQ_LOOKUP) begin
               r.key = hkeys[pos_of[id]];
               r.id = hids[pos_of[id]];
            end else begin
               p = pos_of[id];
               while (p > 0) begin
                  swap_slots(p, (p - 1) / 2);
                  p = (p - 1) / 2;
               end
               take_root(r.key, r.id);
            end
         end
      endcase
      r.count = size[8:0];
      pending.push_back(r);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   task check_result(logic [2:0] st, logic [31:0] k, logic [7:0] d, logic [8:0] c);
      rsp_type e;
      if (pending.size() == 0) begin
         report("unexpected result", 32'(st), 32'h0);
         return;
      end
      e = pending[0];
      pending.delete(0);
      if (st !== e.status) report("status", 32'(st), 32'(e.status));
      if (k !== e.key) report("out_key", k, e.key);
      if (d !== e.id) report("out_id", 32'(d), 32'(e.id));
      if (c !== e.count) report("entry_count", 32'(c), 32'(e.count));
   endtask
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [7:0]  req_item_id = '0;
   logic [31:0] req_item_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_out_key;
   logic [7:0]  rsp_out_id;
   logic [8:0]  rsp_entry_count;

   heap_scoreboard sb = new();
   bit  hold_rsp = 0;
   int  idle_cycles = 0;

   indexed_min_heap dut (.*);

   always #4 clock = ~clock;

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // valid stays high after an accept until the next request or a drain drops it
   task send_request(logic [1:0] op, logic [7:0] id, logic [31:0] key);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_type <= op; req_item_id <= id; req_item_key <= key;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, id, key);
   endtask

   function logic [31:0] rand_key();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   function logic [7:0] pick_id();
      if (sb.size > 0 && $urandom_range(0, 3) != 0)
         return sb.hids[$urandom_range(0, sb.size - 1)];
      return 8'($urandom);
   endfunction

   task wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_status, rsp_out_key, rsp_out_id, rsp_entry_count);
      end
   end

   initial begin
      int mode;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty errors, extremes, duplicates, absent ids
      send_request(hmp_pkg::REQ_POP, 8'h00, 0);
      send_request(hmp_pkg::REQ_LOOKUP, 8'hff, 0);
      send_request(hmp_pkg::REQ_ERASE, 8'h00, 0);
      send_request(hmp_pkg::REQ_PUSH, 8'hff, 32'h7fff_ffff);
      send_request(hmp_pkg::REQ_PUSH, 8'h00, 32'h8000_0000);
      send_request(hmp_pkg::REQ_PUSH, 8'h00, 32'h1);
      send_request(hmp_pkg::REQ_PUSH, 8'h55, 32'h0);
      send_request(hmp_pkg::REQ_PUSH, 8'haa, 32'h0);
      send_request(hmp_pkg::REQ_PUSH, 8'h0f, 32'hffff_ffff);
      send_request(hmp_pkg::REQ_LOOKUP, 8'hff, 0);
      send_request(hmp_pkg::REQ_ERASE, 8'haa, 0);
      send_request(hmp_pkg::REQ_ERASE, 8'haa, 0);
      send_request(hmp_pkg::REQ_POP, 8'h00, 0);
      send_request(hmp_pkg::REQ_POP, 8'h00, 0);
      send_request(hmp_pkg::REQ_POP, 8'h00, 0);
      send_request(hmp_pkg::REQ_POP, 8'h00, 0);
      send_request(hmp_pkg::REQ_POP, 8'h00, 0);
      // fill to capacity with all ids, then push a present id, during a long stall
      hold_rsp = 1;
      for (int i = 0; i < 256; i++) send_request(hmp_pkg::REQ_PUSH, i[7:0], rand_key());
      send_request(hmp_pkg::REQ_PUSH, 8'h10, 0);
      for (int i = 0; i < 40; i++) send_request(hmp_pkg::REQ_ERASE, 8'($urandom), 0);
      for (int i = 0; i < 40; i++) send_request(hmp_pkg::REQ_PUSH, 8'($urandom), rand_key());
      wait_drained();
      // random mix with drifting push/pop balance
      for (int n = 0; n < 1300; n++) begin
         mode = (n / 200) % 3;
         case ($urandom_range(0, 9))
            0, 1, 2: send_request(hmp_pkg::REQ_PUSH, 8'($urandom), rand_key());
            3: send_request(mode == 0 ? hmp_pkg::REQ_PUSH : hmp_pkg::REQ_POP,
                            8'($urandom), rand_key());
            4, 5: send_request(hmp_pkg::REQ_POP, 8'($urandom), rand_key());
            6, 7: send_request(hmp_pkg::REQ_ERASE, pick_id(), rand_key());
            default: send_request(hmp_pkg::REQ_LOOKUP, pick_id(), rand_key());
         endcase
         if (n == 650) wait_drained();
      end
      while (sb.size > 0) send_request(hmp_pkg::REQ_POP, 8'h00, 0);
      wait_drained();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// ===== indexed_min_heap.f =====
rtl/hmp_pkg.sv
rtl/hmp_ram.sv
rtl/hmp_ctrl.sv
rtl/hmp_dp.sv
rtl/indexed_min_heap.sv
rtl/hmp_checker.sv
tb/tb_top.sv
